@@ rtl/core/wsid_pkg.sv @@
`default_nettype none
package wsid_pkg;

  localparam int NUMBER_BITS_DEF = 64;
  localparam int LABEL_BITS_DEF  = 64;
  localparam int TOK_DEPTH_DEF   = 4;

  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;

  typedef enum logic [1:0] {
    TOK_S   = 2'd0,
    TOK_T   = 2'd1,
    TOK_L   = 2'd2,
    TOK_EOI = 2'd3
  } tok_e;

  typedef struct packed {
    logic valid;
    tok_e tok;
  } tok_beat_t;

  typedef enum logic [1:0] {
    ST_COMMAND = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_DROPPED = 2'd2,
    ST_CUT     = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_PUSH   = 5'd0,
    OP_DUP    = 5'd1,
    OP_DROP   = 5'd2,
    OP_SWAP   = 5'd3,
    OP_PICK   = 5'd4,
    OP_SLIDE  = 5'd5,
    OP_LABEL  = 5'd6,
    OP_JUMP   = 5'd7,
    OP_CALL   = 5'd8,
    OP_EXIT   = 5'd9,
    OP_JZ     = 5'd10,
    OP_JN     = 5'd11,
    OP_RETURN = 5'd12,
    OP_ADD    = 5'd13,
    OP_MUL    = 5'd14,
    OP_SUB    = 5'd15,
    OP_DIV    = 5'd16,
    OP_MOD    = 5'd17,
    OP_OUTC   = 5'd18,
    OP_OUTN   = 5'd19,
    OP_READC  = 5'd20,
    OP_READN  = 5'd21,
    OP_STORE  = 5'd22,
    OP_FETCH  = 5'd23
  } op_e;

endpackage
`default_nettype wire

@@ rtl/core/wsid_lexer.sv @@
`default_nettype none
module wsid_lexer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          source_byte_i,
  input  wire logic                end_of_input_i,
  output wsid_pkg::tok_beat_t      beat_o,
  input  wire logic                push_ready_i
);
  import wsid_pkg::*;

  tok_beat_t beat_d, beat_q;
  logic      take;

  assign in_ready_o = !beat_q.valid || push_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign beat_o     = beat_q;

  always_comb begin
    beat_d = beat_q;
    if (beat_q.valid && push_ready_i) begin
      beat_d.valid = 1'b0;
    end
    if (take) begin
      // comment bytes are taken and dropped here
      beat_d.valid = 1'b1;
      priority if (end_of_input_i) begin
        beat_d.tok = TOK_EOI;
      end else if (source_byte_i == CHAR_SPACE) begin
        beat_d.tok = TOK_S;
      end else if (source_byte_i == CHAR_TAB) begin
        beat_d.tok = TOK_T;
      end else if (source_byte_i == CHAR_LF) begin
        beat_d.tok = TOK_L;
      end else begin
        beat_d.valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '{valid: 1'b0, tok: TOK_S};
    end else begin
      beat_q <= beat_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/wsid_tok_fifo.sv @@
`default_nettype none
module wsid_tok_fifo #(
  parameter int DEPTH = wsid_pkg::TOK_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wsid_pkg::tok_beat_t push_i,
  output logic                     push_ready_o,
  output logic                     tok_valid_o,
  output wsid_pkg::tok_e           tok_o,
  input  wire logic                pop_i
);
  import wsid_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  tok_e             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != FULL);
  assign tok_valid_o  = (cnt_q != '0);
  assign tok_o        = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && tok_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL) else $error("token queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> tok_valid_o) else $error("pop from empty token queue");

endmodule
`default_nettype wire

@@ rtl/core/wsid_decoder.sv @@
`default_nettype none
module wsid_decoder #(
  parameter int NUMBER_BITS = wsid_pkg::NUMBER_BITS_DEF,
  parameter int LABEL_BITS  = wsid_pkg::LABEL_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                old_dialect_i,
  input  wire logic                tok_valid_i,
  input  wire wsid_pkg::tok_e      tok_i,
  output logic                     tok_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               status_o,
  output logic [4:0]               opcode_o,
  output logic signed [63:0]       number_value_o,
  output logic [63:0]              label_bits_o,
  output logic [6:0]               label_length_o,
  output logic                     argument_overflow_o
);
  import wsid_pkg::*;

  localparam int ACC_W = (NUMBER_BITS > LABEL_BITS) ? NUMBER_BITS : LABEL_BITS;
  localparam logic [ACC_W-1:0] NUM_MASK = {ACC_W{1'b1}} >> (ACC_W - NUMBER_BITS);
  localparam logic [ACC_W-1:0] LBL_MASK = {ACC_W{1'b1}} >> (ACC_W - LABEL_BITS);
  localparam logic [6:0]       LBL_MAX  = 7'(LABEL_BITS);

  typedef enum logic [4:0] {
    N_START, N_S, N_SS, N_SL, N_ST, N_L, N_LS, N_LL, N_LT,
    N_T, N_TS, N_TSS, N_TST, N_TL, N_TLS, N_TLT, N_TT,
    N_NSIGN, N_NDIG, N_LBL
  } node_e;

  node_e            node_q, node_d;
  logic [ACC_W-1:0] acc_q, acc_d, acc_shift;
  logic             neg_q, neg_d;
  logic [6:0]       cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  op_e              op_q, op_d;

  logic             out_valid_q;
  status_e          status_q;
  op_e              opcode_q;
  logic signed [63:0] num_q;
  logic [63:0]      lbits_q;
  logic [6:0]       llen_q;
  logic             aovf_q;

  logic             take, kbit;
  logic             emit, num_emit, lbl_emit, do_unk, do_simple, do_begin;
  status_e          res_status;
  op_e              res_op, simple_op, begin_op;
  node_e            begin_node;
  logic signed [63:0] res_num;
  logic [63:0]      res_lbits;
  logic [6:0]       res_llen;
  logic             res_ovf;

  logic [NUMBER_BITS-1:0] mag, num_v;
  logic                   num_range;

  assign tok_pop_o = tok_valid_i && (!out_valid_q || out_ready_i);
  assign take      = tok_pop_o;
  assign kbit      = (tok_i == TOK_T);
  assign acc_shift = {acc_q[ACC_W-2:0], kbit};

  // signed value of the gathered magnitude and its range check
  assign mag       = acc_q[NUMBER_BITS-1:0];
  assign num_v     = neg_q ? (~mag + 1'b1) : mag;
  assign num_range = neg_q ? (mag[NUMBER_BITS-1] && (|mag[NUMBER_BITS-2:0]))
                           : mag[NUMBER_BITS-1];

  always_comb begin
    node_d     = node_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    op_d       = op_q;
    emit       = 1'b0;
    num_emit   = 1'b0;
    lbl_emit   = 1'b0;
    do_unk     = 1'b0;
    do_simple  = 1'b0;
    do_begin   = 1'b0;
    simple_op  = OP_PUSH;
    begin_op   = OP_PUSH;
    begin_node = N_START;
    res_status = ST_COMMAND;
    res_op     = OP_PUSH;
    res_num    = '0;
    res_lbits  = '0;
    res_llen   = '0;
    res_ovf    = 1'b0;

    if (take && tok_i == TOK_EOI) begin
      unique case (node_q)
        N_START: begin
          emit = 1'b0;
        end
        N_NSIGN, N_NDIG: begin
          num_emit   = 1'b1;
          res_status = ST_CUT;
        end
        N_LBL: begin
          lbl_emit   = 1'b1;
          res_status = ST_CUT;
        end
        default: begin
          emit       = 1'b1;
          res_status = ST_DROPPED;
        end
      endcase
      node_d = N_START;
    end else if (take) begin
      unique case (node_q)
        N_START: node_d = (tok_i == TOK_S) ? N_S : (tok_i == TOK_T) ? N_T : N_L;
        N_S:     node_d = (tok_i == TOK_S) ? N_SS : (tok_i == TOK_T) ? N_ST : N_SL;
        N_L:     node_d = (tok_i == TOK_S) ? N_LS : (tok_i == TOK_T) ? N_LT : N_LL;
        N_T:     node_d = (tok_i == TOK_S) ? N_TS : (tok_i == TOK_T) ? N_TT : N_TL;
        N_SS: begin
          if (tok_i == TOK_L) begin
            do_unk = 1'b1;
          end else begin
            do_begin   = 1'b1;
            begin_op   = OP_PUSH;
            begin_node = N_NDIG;
          end
        end
        N_SL: begin
          do_simple = 1'b1;
          simple_op = (tok_i == TOK_S) ? OP_DUP : (tok_i == TOK_T) ? OP_SWAP : OP_DROP;
        end
        N_ST: begin
          if (old_dialect_i || tok_i == TOK_T) begin
            do_unk = 1'b1;
          end else begin
            do_begin   = 1'b1;
            begin_op   = (tok_i == TOK_S) ? OP_PICK : OP_SLIDE;
            begin_node = N_NSIGN;
          end
        end
        N_LS: begin
          do_begin   = 1'b1;
          begin_op   = (tok_i == TOK_S) ? OP_LABEL : (tok_i == TOK_T) ? OP_CALL : OP_JUMP;
          begin_node = N_LBL;
        end
        N_LL: begin
          do_simple = (tok_i == TOK_L);
          do_unk    = (tok_i != TOK_L);
          simple_op = OP_EXIT;
        end
        N_LT: begin
          if (tok_i == TOK_L) begin
            do_simple = 1'b1;
            simple_op = OP_RETURN;
          end else begin
            do_begin   = 1'b1;
            begin_op   = (tok_i == TOK_S) ? OP_JZ : OP_JN;
            begin_node = N_LBL;
          end
        end
        N_TS: begin
          if (tok_i == TOK_L) begin
            do_unk = 1'b1;
          end else begin
            node_d = (tok_i == TOK_S) ? N_TSS : N_TST;
          end
        end
        N_TL: begin
          if (tok_i == TOK_L) begin
            do_unk = 1'b1;
          end else begin
            node_d = (tok_i == TOK_S) ? N_TLS : N_TLT;
          end
        end
        N_TSS: begin
          do_simple = 1'b1;
          simple_op = (tok_i == TOK_S) ? OP_ADD : (tok_i == TOK_T) ? OP_SUB : OP_MUL;
        end
        N_TST, N_TLS, N_TLT, N_TT: begin
          do_unk    = (tok_i == TOK_L);
          do_simple = (tok_i != TOK_L);
          unique case (node_q)
            N_TST:   simple_op = kbit ? OP_MOD : OP_DIV;
            N_TLS:   simple_op = kbit ? OP_OUTN : OP_OUTC;
            N_TLT:   simple_op = kbit ? OP_READN : OP_READC;
            default: simple_op = kbit ? OP_FETCH : OP_STORE;
          endcase
        end
        N_NSIGN: begin
          if (tok_i == TOK_L) begin
            num_emit = 1'b1;
          end else begin
            neg_d  = kbit;
            node_d = N_NDIG;
          end
        end
        N_NDIG: begin
          if (tok_i == TOK_L) begin
            num_emit = 1'b1;
          end else begin
            if (acc_q[NUMBER_BITS-1]) begin
              ovf_d = 1'b1;
            end
            acc_d = acc_shift & NUM_MASK;
          end
        end
        N_LBL: begin
          if (tok_i == TOK_L) begin
            lbl_emit = 1'b1;
          end else begin
            acc_d = acc_shift & LBL_MASK;
            if (cnt_q < LBL_MAX) begin
              cnt_d = cnt_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        default: node_d = N_START;
      endcase
    end

    if (do_begin) begin
      op_d   = begin_op;
      node_d = begin_node;
      acc_d  = '0;
      neg_d  = (begin_op == OP_PUSH) ? kbit : 1'b0;
      cnt_d  = '0;
      ovf_d  = 1'b0;
    end
    if (do_unk) begin
      emit       = 1'b1;
      res_status = ST_UNKNOWN;
    end
    if (do_simple) begin
      emit   = 1'b1;
      res_op = simple_op;
    end
    if (num_emit) begin
      emit    = 1'b1;
      res_op  = op_q;
      res_num = 64'(signed'(num_v));
      res_ovf = ovf_q || num_range;
    end
    if (lbl_emit) begin
      emit      = 1'b1;
      res_op    = op_q;
      res_lbits = 64'(acc_q & LBL_MASK);
      res_llen  = cnt_q;
      res_ovf   = ovf_q;
    end
    // every result and end of input drops back to command start
    if (emit || (take && tok_i == TOK_EOI)) begin
      node_d = N_START;
      acc_d  = '0;
      neg_d  = 1'b0;
      cnt_d  = '0;
      ovf_d  = 1'b0;
      op_d   = OP_PUSH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q      <= N_START;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      op_q        <= OP_PUSH;
      out_valid_q <= 1'b0;
    end else begin
      node_q <= node_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      op_q   <= op_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= res_status;
      opcode_q <= res_op;
      num_q    <= res_num;
      lbits_q  <= res_lbits;
      llen_q   <= res_llen;
      aovf_q   <= res_ovf;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign opcode_o            = opcode_q;
  assign number_value_o      = num_q;
  assign label_bits_o        = lbits_q;
  assign label_length_o      = llen_q;
  assign argument_overflow_o = aovf_q;

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i)) else $error("result overwrites held result");
  a_emit_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (node_q == N_START && acc_q == '0)) else $error("decoder not restarted");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LBL_MAX) else $error("label count beyond limit");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_UNKNOWN || status_q == ST_DROPPED))
      |-> (opcode_q == OP_PUSH && num_q == '0 && llen_q == '0))
    else $error("error result carries argument");

endmodule
`default_nettype wire

@@ rtl/core/whitespace_instruction_decoder.sv @@
// Path: lexer beat register, token queue, then the decoder result register.
// Throughput: one source byte per cycle while the token queue has room; the
//   decode step and the shift accumulator in the back end each handle one
//   token a cycle while no held result waits for the output side.
// Reset: asynchronous, active low; decoder at command start, token queue
//   empty, no result held, old dialect off.
`default_nettype none
module whitespace_instruction_decoder #(
  parameter int NUMBER_BITS = wsid_pkg::NUMBER_BITS_DEF,
  parameter int LABEL_BITS  = wsid_pkg::LABEL_BITS_DEF,
  parameter int TOK_DEPTH   = wsid_pkg::TOK_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_old_dialect_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    source_byte_i,
  input  wire logic          end_of_input_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [1:0]         status_o,
  output logic [4:0]         opcode_o,
  output logic signed [63:0] number_value_o,
  output logic [63:0]        label_bits_o,
  output logic [6:0]         label_length_o,
  output logic               argument_overflow_o
);
  import wsid_pkg::*;

  logic      old_dialect_q;
  tok_beat_t beat;
  logic      push_ready, tok_valid, tok_pop;
  tok_e      tok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_dialect_q <= 1'b0;
    end else if (cfg_valid_i) begin
      old_dialect_q <= cfg_old_dialect_i;
    end
  end

  wsid_lexer u_lexer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .source_byte_i  (source_byte_i),
    .end_of_input_i (end_of_input_i),
    .beat_o         (beat),
    .push_ready_i   (push_ready)
  );

  wsid_tok_fifo #(
    .DEPTH (TOK_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (beat),
    .push_ready_o (push_ready),
    .tok_valid_o  (tok_valid),
    .tok_o        (tok),
    .pop_i        (tok_pop)
  );

  wsid_decoder #(
    .NUMBER_BITS (NUMBER_BITS),
    .LABEL_BITS  (LABEL_BITS)
  ) u_decoder (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .old_dialect_i       (old_dialect_q),
    .tok_valid_i         (tok_valid),
    .tok_i               (tok),
    .tok_pop_o           (tok_pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .opcode_o            (opcode_o),
    .number_value_o      (number_value_o),
    .label_bits_o        (label_bits_o),
    .label_length_o      (label_length_o),
    .argument_overflow_o (argument_overflow_o)
  );

endmodule
`default_nettype wire

@@ dv/whitespace_instruction_decoder_tb.sv @@
`timescale 1ns / 1ps
module whitespace_instruction_decoder_tb;
  import wsid_pkg::*;

  localparam int ITEMS_PER_PHASE = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int IDLE_LIMIT      = 4000;
  localparam int PRINT_LIMIT     = 50;

  typedef enum logic [4:0] {
    DN_START, DN_S, DN_SS, DN_SL, DN_ST, DN_L, DN_LS, DN_LL, DN_LT,
    DN_T, DN_TS, DN_TSS, DN_TST, DN_TL, DN_TLS, DN_TLT, DN_TT,
    DN_NSIGN, DN_NDIG, DN_LBL
  } node_e;

  typedef struct packed {
    status_e     status;
    op_e         opcode;
    logic [63:0] number_value;
    logic [63:0] label_bits;
    logic [6:0]  label_length;
    logic        overflow;
  } decoded_t;

  typedef struct {
    string    src;
    bit       has_exp;
    decoded_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_old_dialect_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  source_byte_i = 8'd0;
  logic        end_of_input_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [4:0]  opcode_o;
  logic signed [63:0] number_value_o;
  logic [63:0] label_bits_o;
  logic [6:0]  label_length_o;
  logic        argument_overflow_o;

  // expectation typed into the directed table, carried along with the byte
  bit       typed_v = 1'b0;
  decoded_t typed_exp = '0;

  whitespace_instruction_decoder dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_old_dialect_i   (cfg_old_dialect_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .source_byte_i       (source_byte_i),
    .end_of_input_i      (end_of_input_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .opcode_o            (opcode_o),
    .number_value_o      (number_value_o),
    .label_bits_o        (label_bits_o),
    .label_length_o      (label_length_o),
    .argument_overflow_o (argument_overflow_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------
  node_e       node_q;
  logic [63:0] acc_q;
  logic        neg_q;
  logic [6:0]  cnt_q;
  logic        ovf_q;
  op_e         pend_q;
  logic        dialect_q = 1'b0;

  decoded_t expected_cmds[$];
  int       mismatches = 0;

  function automatic void clear_decoder();
    node_q = DN_START;
    acc_q  = '0;
    neg_q  = 1'b0;
    cnt_q  = '0;
    ovf_q  = 1'b0;
    pend_q = OP_PUSH;
  endfunction

  function automatic void begin_arg(op_e op, node_e nd);
    clear_decoder();
    pend_q = op;
    node_q = nd;
  endfunction

  function automatic decoded_t finish_result(status_e st, op_e op, logic [63:0] num,
                                             logic [63:0] lb, logic [6:0] ll, logic ov);
    decoded_t r;
    r.status       = st;
    r.opcode       = op;
    r.number_value = num;
    r.label_bits   = lb;
    r.label_length = ll;
    r.overflow     = ov;
    clear_decoder();
    return r;
  endfunction

  function automatic decoded_t number_result(status_e st);
    logic [63:0] half;
    logic        ov;
    half = 64'h8000_0000_0000_0000;
    ov   = ovf_q;
    if (neg_q ? (acc_q > half) : (acc_q >= half)) ov = 1'b1;
    return finish_result(st, pend_q, neg_q ? -acc_q : acc_q, '0, '0, ov);
  endfunction

  function automatic decoded_t label_result(status_e st);
    return finish_result(st, pend_q, '0, acc_q, cnt_q, ovf_q);
  endfunction

  function automatic decoded_t simple_result(op_e op);
    return finish_result(ST_COMMAND, op, '0, '0, '0, 1'b0);
  endfunction

  function automatic decoded_t unknown_result();
    return finish_result(ST_UNKNOWN, OP_PUSH, '0, '0, '0, 1'b0);
  endfunction

  // Advance the decoder by one source byte; returns 1 when a result is issued.
  function automatic bit decode_step(logic [7:0] b, logic e, output decoded_t r);
    tok_e k;
    bit   got;
    r   = '0;
    got = 1'b0;
    if (e) begin
      case (node_q)
        DN_START: begin
          clear_decoder();
          return 1'b0;
        end
        DN_NSIGN, DN_NDIG: r = number_result(ST_CUT);
        DN_LBL:            r = label_result(ST_CUT);
        default:           r = finish_result(ST_DROPPED, OP_PUSH, '0, '0, '0, 1'b0);
      endcase
      return 1'b1;
    end
    case (b)
      CHAR_SPACE: k = TOK_S;
      CHAR_TAB:   k = TOK_T;
      CHAR_LF:    k = TOK_L;
      default:    return 1'b0;
    endcase
    case (node_q)
      DN_START: node_q = (k == TOK_S) ? DN_S : (k == TOK_T) ? DN_T : DN_L;
      DN_S:     node_q = (k == TOK_S) ? DN_SS : (k == TOK_T) ? DN_ST : DN_SL;
      DN_SS: begin
        if (k == TOK_L) begin
          r = unknown_result();
          got = 1'b1;
        end else begin
          begin_arg(OP_PUSH, DN_NDIG);
          neg_q = (k == TOK_T);
        end
      end
      DN_SL: begin
        r = simple_result((k == TOK_S) ? OP_DUP : (k == TOK_T) ? OP_SWAP : OP_DROP);
        got = 1'b1;
      end
      DN_ST: begin
        if (dialect_q || k == TOK_T) begin
          r = unknown_result();
          got = 1'b1;
        end else begin
          begin_arg((k == TOK_S) ? OP_PICK : OP_SLIDE, DN_NSIGN);
        end
      end
      DN_L:  node_q = (k == TOK_S) ? DN_LS : (k == TOK_T) ? DN_LT : DN_LL;
      DN_LS: begin_arg((k == TOK_S) ? OP_LABEL : (k == TOK_T) ? OP_CALL : OP_JUMP, DN_LBL);
      DN_LL: begin
        r = (k == TOK_L) ? simple_result(OP_EXIT) : unknown_result();
        got = 1'b1;
      end
      DN_LT: begin
        if (k == TOK_L) begin
          r = simple_result(OP_RETURN);
          got = 1'b1;
        end else begin
          begin_arg((k == TOK_S) ? OP_JZ : OP_JN, DN_LBL);
        end
      end
      DN_T: node_q = (k == TOK_S) ? DN_TS : (k == TOK_T) ? DN_TT : DN_TL;
      DN_TS, DN_TL: begin
        if (k == TOK_L) begin
          r = unknown_result();
          got = 1'b1;
        end else if (node_q == DN_TS) begin
          node_q = (k == TOK_S) ? DN_TSS : DN_TST;
        end else begin
          node_q = (k == TOK_S) ? DN_TLS : DN_TLT;
        end
      end
      DN_TSS: begin
        r = simple_result((k == TOK_S) ? OP_ADD : (k == TOK_T) ? OP_SUB : OP_MUL);
        got = 1'b1;
      end
      DN_TST, DN_TLS, DN_TLT, DN_TT: begin
        got = 1'b1;
        if (k == TOK_L) r = unknown_result();
        else case (node_q)
          DN_TST:  r = simple_result((k == TOK_S) ? OP_DIV : OP_MOD);
          DN_TLS:  r = simple_result((k == TOK_S) ? OP_OUTC : OP_OUTN);
          DN_TLT:  r = simple_result((k == TOK_S) ? OP_READC : OP_READN);
          default: r = simple_result((k == TOK_S) ? OP_STORE : OP_FETCH);
        endcase
      end
      DN_NSIGN: begin
        if (k == TOK_L) begin
          r = number_result(ST_COMMAND);
          got = 1'b1;
        end else begin
          neg_q  = (k == TOK_T);
          node_q = DN_NDIG;
        end
      end
      DN_NDIG: begin
        if (k == TOK_L) begin
          r = number_result(ST_COMMAND);
          got = 1'b1;
        end else begin
          // a one about to fall off the top means the magnitude no longer fits
          if (acc_q[63]) ovf_q = 1'b1;
          acc_q = {acc_q[62:0], k == TOK_T};
        end
      end
      DN_LBL: begin
        if (k == TOK_L) begin
          r = label_result(ST_COMMAND);
          got = 1'b1;
        end else begin
          acc_q = {acc_q[62:0], k == TOK_T};
          if (cnt_q < 7'd64) cnt_q = cnt_q + 7'd1;
          else ovf_q = 1'b1;
        end
      end
      default: clear_decoder();
    endcase
    return got;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(decoded_t want);
    if (status_o !== want.status)
      report_mismatch("status", 64'(status_o), 64'(want.status));
    if (opcode_o !== want.opcode)
      report_mismatch("opcode", 64'(opcode_o), 64'(want.opcode));
    if (number_value_o !== want.number_value)
      report_mismatch("number_value", number_value_o, want.number_value);
    if (label_bits_o !== want.label_bits)
      report_mismatch("label_bits", label_bits_o, want.label_bits);
    if (label_length_o !== want.label_length)
      report_mismatch("label_length", 64'(label_length_o), 64'(want.label_length));
    if (argument_overflow_o !== want.overflow)
      report_mismatch("argument_overflow", 64'(argument_overflow_o), 64'(want.overflow));
  endtask

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    decoded_t r;
    bit       hit;
    bit       moved;
    moved = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      dialect_q = cfg_old_dialect_i;
      moved = 1'b1;
    end
    if (out_valid_o && out_ready_i) begin
      moved = 1'b1;
      if (expected_cmds.size() == 0)
        report_mismatch("result with none expected", 64'(status_o), '0);
      else check_result(expected_cmds.pop_front());
    end
    if (in_valid_i && in_ready_o) begin
      moved = 1'b1;
      hit = decode_step(source_byte_i, end_of_input_i, r);
      if (typed_v) expected_cmds.push_back(typed_exp);
      else if (hit) expected_cmds.push_back(r);
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stall pattern switches among four randomly chosen modes.
  int rdy_cyc = 0;
  int rdy_mode = 0;

  always @(posedge clk_i) begin
    rdy_cyc++;
    if (rdy_cyc % 64 == 0) rdy_mode = $urandom_range(0, 3);
    case (rdy_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      2:       out_ready_i <= (rdy_cyc % 8) < 5;
      default: out_ready_i <= (rdy_cyc % 13) >= 9;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  int   burst_left = 0;
  int   tokens_sent = 0;
  tok_e cmd_toks[$];

  task automatic send_item(logic [7:0] b, logic e, bit typed, decoded_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    source_byte_i  <= b;
    end_of_input_i <= e;
    typed_v        <= typed;
    typed_exp      <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    if (e || b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF) tokens_sent++;
  endtask

  function automatic logic [7:0] comment_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF);
    return b;
  endfunction

  task automatic send_tok(tok_e k);
    if ($urandom_range(0, 11) == 0) send_item(comment_byte(), 1'b0, 1'b0, '0);
    send_item((k == TOK_S) ? CHAR_SPACE : (k == TOK_T) ? CHAR_TAB : CHAR_LF,
              1'b0, 1'b0, '0);
  endtask

  task automatic send_eoi();
    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  function automatic void queue_str(string s);
    for (int i = 0; i < s.len(); i++)
      cmd_toks.push_back((s[i] == "S") ? TOK_S : (s[i] == "T") ? TOK_T : TOK_L);
  endfunction

  // Mostly short arguments; a few straddle the 64-bit edge.
  function automatic int arg_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return $urandom_range(0, 12);
    if (r < 90) return $urandom_range(13, 40);
    return ($urandom_range(0, 1) != 0) ? 64 : $urandom_range(60, 70);
  endfunction

  function automatic void queue_digits(int n);
    int m;
    m = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      if (m == 4) cmd_toks.push_back(TOK_T);
      else if (m == 5) cmd_toks.push_back((i == 0) ? TOK_T : TOK_S);
      else cmd_toks.push_back(($urandom_range(0, 1) != 0) ? TOK_T : TOK_S);
    end
  endfunction

  task automatic send_command();
    int    sel;
    int    cut;
    op_e   op;
    string pre;
    bit    is_num;
    bit    is_lbl;
    cmd_toks.delete();
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      op = op_e'($urandom_range(0, 23));
      is_num = 1'b0;
      is_lbl = 1'b0;
      case (op)
        OP_PUSH:   begin pre = "SS";  is_num = 1'b1; end
        OP_DUP:    pre = "SLS";
        OP_DROP:   pre = "SLL";
        OP_SWAP:   pre = "SLT";
        OP_PICK:   begin pre = "STS"; is_num = 1'b1; end
        OP_SLIDE:  begin pre = "STL"; is_num = 1'b1; end
        OP_LABEL:  begin pre = "LSS"; is_lbl = 1'b1; end
        OP_JUMP:   begin pre = "LSL"; is_lbl = 1'b1; end
        OP_CALL:   begin pre = "LST"; is_lbl = 1'b1; end
        OP_EXIT:   pre = "LLL";
        OP_JZ:     begin pre = "LTS"; is_lbl = 1'b1; end
        OP_JN:     begin pre = "LTT"; is_lbl = 1'b1; end
        OP_RETURN: pre = "LTL";
        OP_ADD:    pre = "TSSS";
        OP_MUL:    pre = "TSSL";
        OP_SUB:    pre = "TSST";
        OP_DIV:    pre = "TSTS";
        OP_MOD:    pre = "TSTT";
        OP_OUTC:   pre = "TLSS";
        OP_OUTN:   pre = "TLST";
        OP_READC:  pre = "TLTS";
        OP_READN:  pre = "TLTT";
        OP_STORE:  pre = "TTS";
        default:   pre = "TTT";
      endcase
      queue_str(pre);
      if (is_num) begin
        cut = $urandom_range(0, 19);
        // a line feed as sign: empty number, or an unknown push
        if (cut == 0) begin
          cmd_toks.push_back(TOK_L);
        end else begin
          cmd_toks.push_back((cut < 10) ? TOK_S : TOK_T);
          queue_digits(arg_len());
          cmd_toks.push_back(TOK_L);
        end
      end else if (is_lbl) begin
        queue_digits(arg_len());
        cmd_toks.push_back(TOK_L);
      end
      // truncate some commands and end the source inside them
      if (sel >= 72) begin
        cut = $urandom_range(1, cmd_toks.size() - 1);
        while (cmd_toks.size() > cut) void'(cmd_toks.pop_back());
      end
      foreach (cmd_toks[i]) send_tok(cmd_toks[i]);
      if (sel >= 72) send_eoi();
    end else if (sel < 95) begin
      repeat ($urandom_range(1, 5)) send_tok(tok_e'($urandom_range(0, 2)));
    end else begin
      send_eoi();
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dialect(logic v);
    cfg_valid_i       <= 1'b1;
    cfg_old_dialect_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  dir_row_t dir_rows[$];

  function automatic void add_row(string s, bit h, status_e st, op_e op, logic [63:0] num);
    dir_row_t row;
    row.src  = s;
    row.has_exp = h;
    row.want = '0;
    row.want.status = st;
    row.want.opcode = op;
    row.want.number_value = num;
    dir_rows.push_back(row);
  endfunction

  initial begin
    int       goal;
    bit       last;
    byte      c;
    decoded_t want;
    clear_decoder();
    // S T L are tokens, E ends the source, 0 and F are the byte extremes as comments
    add_row("E",      1'b0, ST_COMMAND, OP_PUSH,  64'd0);
    add_row("0SFLS",  1'b1, ST_COMMAND, OP_DUP,   64'd0);
    add_row("LLL",    1'b1, ST_COMMAND, OP_EXIT,  64'd0);
    add_row("SSL",    1'b1, ST_UNKNOWN, OP_PUSH,  64'd0);
    add_row("STLL",   1'b1, ST_COMMAND, OP_SLIDE, 64'd0);
    add_row("LSTTSL", 1'b0, ST_COMMAND, OP_PUSH,  64'd0);
    add_row("TE",     1'b1, ST_DROPPED, OP_PUSH,  64'd0);
    add_row("SSTTE",  1'b1, ST_CUT,     OP_PUSH,  '1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      want = dir_rows[i].want;
      for (int j = 0; j < dir_rows[i].src.len(); j++) begin
        c    = dir_rows[i].src[j];
        last = dir_rows[i].has_exp && (j == dir_rows[i].src.len() - 1);
        case (c)
          "S":     send_item(CHAR_SPACE, 1'b0, last, want);
          "T":     send_item(CHAR_TAB, 1'b0, last, want);
          "L":     send_item(CHAR_LF, 1'b0, last, want);
          "E":     send_item(8'($urandom_range(0, 255)), 1'b1, last, want);
          "0":     send_item(8'h00, 1'b0, last, want);
          default: send_item(8'hFF, 1'b0, last, want);
        endcase
      end
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_dialect(ph % 2 == 0);
      goal = tokens_sent + ITEMS_PER_PHASE;
      while (tokens_sent < goal) send_command();
      send_eoi();
      drain();
    end

    if (expected_cmds.size() != 0)
      report_mismatch("results never issued", 64'(expected_cmds.size()), '0);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
